/* rtl/core/acfm_pkg.sv */
// Package for the adaptive cumulative-frequency interval model.
// Holds the sequencer state type, command and status codes and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acfm_pkg;

  localparam int FREQ_W = 32;
  localparam int SUM_W  = 33;

  // scale of all bounds
  localparam logic [SUM_W-1:0] ONE = 33'h0_8000_0000;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_FIND  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_WALK,
    ST_WALK_WR,
    ST_RS_RD,
    ST_RS_CHK,
    ST_RS_NEXT,
    ST_FIN_RD,
    ST_FIN,
    ST_Q_RD,
    ST_Q_FREQ,
    ST_Q_WALK,
    ST_Q_ADD,
    ST_F_RD,
    ST_F_SUM,
    ST_F_LEAF,
    ST_F_LEAF_ADD,
    ST_DIV_LD,
    ST_DIV,
    ST_DIV_DONE,
    ST_MUL,
    ST_CMP,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/adaptive_cumfreq_interval_model.sv */
// Adaptive cumulative-frequency interval model for an arithmetic coder.
// Uses acfm_pkg. Frequency table and left-sum tree live in internal memories.
//
// Input channel (in_valid/in_ready) takes one command beat: set frequency,
// query symbol bounds, or find symbol at value. Output channel
// (out_valid/out_ready) returns exactly one result beat per command.
// The block works on one command at a time; in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next command may be taken while the receiver stalls; a second result then
// waits in the sequencer until the output register frees up.
// Work per command:
//   set without rescale: a walk from the leaf to the root, with a read-modify-write
//                        of the parent wherever the path comes from a left child
//   each rescale pass:   halves every frequency above one and walks its path; the
//                        passes repeat while the total stays above 2^31
//   query: tree walk plus two 32-step divisions
//   find:  per level a 32-step divide and a multiply
// The divider yields one quotient bit per cycle. After reset a clearing pass loads
// every frequency with one and builds the tree; in_ready stays low until it finishes.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_cumfreq_interval_model #(
  parameter int SYM_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  symbol,
  input  wire logic [31:0] new_frequency,
  input  wire logic [31:0] range_low,
  input  wire logic [31:0] range_high,
  input  wire logic [31:0] value_low,
  input  wire logic [31:0] value_high,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      interval_lo,
  output logic [31:0]      interval_hi,
  output logic [31:0]      symbol_frequency,
  output logic [31:0]      total_count,
  output logic [7:0]       found_symbol,
  output logic             found
);
  import acfm_pkg::*;

  localparam int LEVELS = $clog2(SYM_COUNT);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = LEAVES - 1;
  localparam int NODE_W = LEVELS + 1;
  localparam int SW     = LEVELS + 1;

  state_t state, state_next;

  // memories
  logic [FREQ_W-1:0] freq_mem [SYM_COUNT];
  logic [SUM_W-1:0]  tree_mem [NODES];
  logic [FREQ_W-1:0] fq_rdata, fq_wdata;
  logic [SUM_W-1:0]  tr_rdata, tr_wdata;
  logic [LEVELS-1:0] fq_raddr, fq_waddr, tr_raddr, tr_waddr;
  logic              fq_we, tr_we;

  // control
  logic [LEVELS-1:0] cnt, cnt_next;
  logic [SW-1:0]     start, start_next, half, half_next;
  logic [SUM_W-1:0]  total, total_next;
  logic              out_valid_next;
  logic              rescale, rescale_next;

  // working registers
  logic [NODE_W-1:0] node, node_next;
  logic [SUM_W-1:0]  acc, acc_next, cum, cum_next, diff, diff_next;
  logic              phase, phase_next;
  logic [SUM_W-1:0]  div_r, div_r_next;
  logic [31:0]       div_q, div_q_next;
  logic [4:0]        div_cnt, div_cnt_next;
  logic [63:0]       prod, prod_next;
  logic [1:0]        cmd_r, cmd_r_next;
  logic [7:0]        sym_r, sym_r_next;
  logic [31:0]       nf_r, nf_r_next, rl_r, rl_r_next, rh_r, rh_r_next;
  logic [31:0]       vl_r, vl_r_next, vh_r, vh_r_next;
  logic [1:0]        res_status, res_status_next;
  logic [31:0]       res_lower, res_lower_next, res_upper, res_upper_next;
  logic [31:0]       res_freq, res_freq_next;
  logic [7:0]        res_fsym, res_fsym_next;
  logic              res_found, res_found_next;
  logic [1:0]        status_next;
  logic [31:0]       lower_next, upper_next, sfreq_next, tcount_next;
  logic [7:0]        fsym_next;
  logic              found_next;

  // derived values
  logic              in_range, sym_in_range;
  logic [NODE_W-1:0] parent, leaf, node_step, walk_start;
  logic              leaf_ok;
  logic [SUM_W-1:0]  div_r2;
  logic              div_ge;
  logic [31:0]       span;
  logic [33:0]       point;
  logic              go_right;
  logic [SW-1:0]     init_rem, init_sum;
  logic [SUM_W-1:0]  init_val;
  logic              init_node, init_leaf;

  assign in_ready     = (state == ST_IDLE);
  assign in_range     = 32'(symbol) < SYM_COUNT;
  assign sym_in_range = 32'(sym_r) < SYM_COUNT;
  assign parent       = (node - NODE_W'(1)) >> 1;
  assign leaf         = node - NODE_W'(NODES);
  assign leaf_ok      = 32'(leaf) < SYM_COUNT;
  assign walk_start   = NODE_W'(NODES) + NODE_W'(sym_r);

  // shared restoring divider: quotient of cum * 2^31 / total
  assign div_r2 = (div_cnt == 5'd0) ? div_r : {div_r[SUM_W-2:0], 1'b0};
  assign div_ge = div_r2 >= {1'b0, total[31:0]};

  assign span      = (rh_r >= rl_r) ? rh_r - rl_r : 32'd0;
  assign point     = {2'b00, rl_r} + 34'(prod[63:31]);
  assign go_right  = point <= {2'b00, vl_r};
  assign node_step = go_right ? (node << 1) + NODE_W'(2) : (node << 1) + NODE_W'(1);

  // reset image of the tree: left-subtree leaf counts
  assign init_node = cnt != LEVELS'(LEAVES - 1);
  assign init_leaf = 32'(cnt) < SYM_COUNT;
  assign init_rem  = SW'(SYM_COUNT) - start;
  assign init_sum  = start + (half << 1);
  always_comb begin
    if (start >= SW'(SYM_COUNT)) begin
      init_val = '0;
    end else if (init_rem < half) begin
      init_val = SUM_W'(init_rem);
    end else begin
      init_val = SUM_W'(half);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: if (cnt == LEVELS'(LEAVES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          priority if (command == CMD_SET) begin
            state_next = in_range ? ST_SET_RD : ST_OUT;
          end else if (command == CMD_QUERY) begin
            state_next = in_range ? ST_Q_RD : ST_OUT;
          end else if (command == CMD_FIND) begin
            state_next = (total == '0) ? ST_OUT : ST_F_RD;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SET_RD:  state_next = ST_SET_WR;
      ST_SET_WR:  state_next = ST_WALK;
      ST_WALK: begin
        if (node == '0) begin
          if (rescale) state_next = ST_RS_NEXT;
          else if (total > ONE) state_next = ST_RS_RD;
          else state_next = ST_FIN_RD;
        end else if (node[0]) begin
          state_next = ST_WALK_WR;
        end
      end
      ST_WALK_WR: state_next = ST_WALK;
      ST_RS_RD:   state_next = ST_RS_CHK;
      ST_RS_CHK:  state_next = (fq_rdata > 32'd1) ? ST_WALK : ST_RS_NEXT;
      ST_RS_NEXT: begin
        if (cnt == LEVELS'(SYM_COUNT - 1) && !(total > ONE)) state_next = ST_FIN_RD;
        else state_next = ST_RS_RD;
      end
      ST_FIN_RD:  state_next = ST_FIN;
      ST_FIN:     state_next = ST_OUT;
      ST_Q_RD:    state_next = ST_Q_FREQ;
      ST_Q_FREQ:  state_next = (total == '0) ? ST_OUT : ST_Q_WALK;
      ST_Q_WALK: begin
        if (node == '0) state_next = ST_DIV_LD;
        else if (!node[0]) state_next = ST_Q_ADD;
      end
      ST_Q_ADD:   state_next = ST_Q_WALK;
      ST_F_RD:    state_next = ST_F_SUM;
      ST_F_SUM:   state_next = ST_DIV_LD;
      ST_F_LEAF:  state_next = leaf_ok ? ST_F_LEAF_ADD : ST_DIV_LD;
      ST_F_LEAF_ADD: state_next = ST_DIV_LD;
      ST_DIV_LD:  state_next = ST_DIV;
      ST_DIV:     if (div_cnt == 5'd31) state_next = ST_DIV_DONE;
      ST_DIV_DONE: begin
        if (cmd_r == CMD_QUERY) state_next = phase ? ST_OUT : ST_DIV_LD;
        else state_next = ST_MUL;
      end
      ST_MUL:     state_next = ST_CMP;
      ST_CMP: begin
        if (phase) state_next = ST_OUT;
        else if (node_step < NODE_W'(NODES)) state_next = ST_F_RD;
        else state_next = ST_F_LEAF;
      end
      ST_OUT:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_next = cnt;  start_next = start;  half_next = half;
    total_next = total;  rescale_next = rescale;
    node_next = node;  acc_next = acc;  cum_next = cum;  diff_next = diff;
    phase_next = phase;
    div_r_next = div_r;  div_q_next = div_q;  div_cnt_next = div_cnt;
    prod_next = prod;
    cmd_r_next = cmd_r;  sym_r_next = sym_r;  nf_r_next = nf_r;
    rl_r_next = rl_r;  rh_r_next = rh_r;  vl_r_next = vl_r;  vh_r_next = vh_r;
    res_status_next = res_status;  res_lower_next = res_lower;
    res_upper_next = res_upper;  res_freq_next = res_freq;
    res_fsym_next = res_fsym;  res_found_next = res_found;
    fq_raddr = LEVELS'(sym_r);
    fq_waddr = cnt;  fq_wdata = 32'd1;  fq_we = 1'b0;
    tr_raddr = parent[LEVELS-1:0];
    tr_waddr = parent[LEVELS-1:0];  tr_wdata = tr_rdata + diff;  tr_we = 1'b0;
    unique case (state)
      ST_INIT: begin
        fq_we = init_leaf;
        tr_we = init_node;
        tr_waddr = cnt;
        tr_wdata = init_val;
        cnt_next = cnt + LEVELS'(1);
        if (init_node) begin
          if (init_sum == SW'(LEAVES)) begin
            start_next = '0;
            half_next  = half >> 1;
          end else begin
            start_next = init_sum;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_r_next = command;  sym_r_next = symbol;  nf_r_next = new_frequency;
          rl_r_next = range_low;  rh_r_next = range_high;
          vl_r_next = value_low;  vh_r_next = value_high;
          res_lower_next = '0;  res_upper_next = '0;  res_freq_next = '0;
          res_fsym_next = '0;  res_found_next = 1'b0;
          res_status_next = STAT_OK;
          if ((command == CMD_SET || command == CMD_QUERY) && !in_range) begin
            res_status_next = STAT_RANGE;
          end else if (command == CMD_FIND && total == '0) begin
            res_status_next = STAT_ZERO;
          end
          acc_next  = '0;
          node_next = '0;
        end
      end
      ST_SET_WR: begin
        diff_next    = {1'b0, nf_r} - {1'b0, fq_rdata};
        total_next   = total + ({1'b0, nf_r} - {1'b0, fq_rdata});
        fq_we        = 1'b1;
        fq_waddr     = LEVELS'(sym_r);
        fq_wdata     = nf_r;
        node_next    = walk_start;
        rescale_next = 1'b0;
      end
      ST_WALK: begin
        if (node == '0) begin
          if (!rescale && total > ONE) begin
            rescale_next = 1'b1;
            cnt_next     = '0;
          end
        end else if (!node[0]) begin
          node_next = parent;
        end
      end
      ST_WALK_WR: begin
        tr_we     = 1'b1;
        node_next = parent;
      end
      ST_RS_RD: fq_raddr = cnt;
      ST_RS_CHK: begin
        if (fq_rdata > 32'd1) begin
          diff_next  = {1'b0, fq_rdata >> 1} - {1'b0, fq_rdata};
          total_next = total + ({1'b0, fq_rdata >> 1} - {1'b0, fq_rdata});
          fq_we      = 1'b1;
          fq_waddr   = cnt;
          fq_wdata   = fq_rdata >> 1;
          node_next  = NODE_W'(NODES) + NODE_W'(cnt);
        end
      end
      ST_RS_NEXT: begin
        if (cnt == LEVELS'(SYM_COUNT - 1)) cnt_next = '0;
        else cnt_next = cnt + LEVELS'(1);
      end
      ST_FIN: res_freq_next = fq_rdata;
      ST_Q_FREQ: begin
        res_freq_next = fq_rdata;
        if (total == '0) res_status_next = STAT_ZERO;
        acc_next  = '0;
        node_next = walk_start;
      end
      ST_Q_WALK: begin
        if (node == '0) begin
          cum_next   = acc;
          phase_next = 1'b0;
        end else if (node[0]) begin
          node_next = parent;
        end
      end
      ST_Q_ADD: begin
        acc_next  = acc + tr_rdata;
        node_next = parent;
      end
      ST_F_RD: tr_raddr = node[LEVELS-1:0];
      ST_F_SUM: begin
        cum_next   = acc + tr_rdata;
        phase_next = 1'b0;
      end
      ST_F_LEAF: begin
        res_fsym_next = 8'(leaf);
        fq_raddr      = leaf[LEVELS-1:0];
        phase_next    = 1'b1;
        cum_next      = acc;
        if (!leaf_ok) res_status_next = STAT_RANGE;
      end
      ST_F_LEAF_ADD: cum_next = acc + {1'b0, fq_rdata};
      ST_DIV_LD: begin
        div_r_next   = cum;
        div_q_next   = '0;
        div_cnt_next = '0;
      end
      ST_DIV: begin
        div_r_next   = div_ge ? div_r2 - {1'b0, total[31:0]} : div_r2;
        div_q_next   = {div_q[30:0], div_ge};
        div_cnt_next = div_cnt + 5'd1;
      end
      ST_DIV_DONE: begin
        if (cmd_r == CMD_QUERY) begin
          if (phase) begin
            res_upper_next = div_q;
          end else begin
            res_lower_next = div_q;
            cum_next       = acc + {1'b0, res_freq};
            phase_next     = 1'b1;
          end
        end
      end
      ST_MUL: prod_next = span * div_q;
      ST_CMP: begin
        if (phase) begin
          res_found_next = point >= {2'b00, vh_r};
        end else begin
          if (go_right) acc_next = cum;
          node_next = node_step;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_next = out_valid;
    status_next = status;  lower_next = interval_lo;  upper_next = interval_hi;
    sfreq_next = symbol_frequency;  tcount_next = total_count;
    fsym_next = found_symbol;  found_next = found;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid_next = 1'b1;
      status_next = res_status;  lower_next = res_lower;  upper_next = res_upper;
      sfreq_next = res_freq;  tcount_next = total[31:0];
      fsym_next = res_fsym;  found_next = res_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
      cnt       <= '0;
      start     <= '0;
      half      <= SW'(LEAVES / 2);
      total     <= SUM_W'(SYM_COUNT);
      rescale   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      start     <= start_next;
      half      <= half_next;
      total     <= total_next;
      rescale   <= rescale_next;
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;  acc <= acc_next;  cum <= cum_next;  diff <= diff_next;
    phase <= phase_next;
    div_r <= div_r_next;  div_q <= div_q_next;  div_cnt <= div_cnt_next;
    prod <= prod_next;
    cmd_r <= cmd_r_next;  sym_r <= sym_r_next;  nf_r <= nf_r_next;
    rl_r <= rl_r_next;  rh_r <= rh_r_next;  vl_r <= vl_r_next;  vh_r <= vh_r_next;
    res_status <= res_status_next;  res_lower <= res_lower_next;
    res_upper <= res_upper_next;  res_freq <= res_freq_next;
    res_fsym <= res_fsym_next;  res_found <= res_found_next;
    status <= status_next;  interval_lo <= lower_next;  interval_hi <= upper_next;
    symbol_frequency <= sfreq_next;  total_count <= tcount_next;
    found_symbol <= fsym_next;  found <= found_next;
  end

  always_ff @(posedge clk) begin
    if (fq_we) freq_mem[fq_waddr] <= fq_wdata;
    fq_rdata <= freq_mem[fq_raddr];
  end

  always_ff @(posedge clk) begin
    if (tr_we) tree_mem[tr_waddr] <= tr_wdata;
    tr_rdata <= tree_mem[tr_raddr];
  end

  // rescaling always leaves the total at or below the bound scale
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (total <= ONE))
    else $error("total above scale while idle");

  // a tree update never targets the root's parent
  a_walk_nonroot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_WR) |-> (node != '0))
    else $error("tree update past root");

  // quotient is used only after a full divide sequence
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_DONE) |-> ($past(state) == ST_DIV && $past(div_cnt) == 5'd31))
    else $error("divide result taken early");

  // a set command only touches state when its symbol is in range
  a_set_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SET_WR) |-> sym_in_range)
    else $error("set of out-of-range symbol");

endmodule

`default_nettype wire

/* tb/acfm_checker.sv */
// Checker for adaptive_cumfreq_interval_model: watches both channels, predicts each
// result beat from its own copy of the frequency table and compares each beat as a whole.
// Depends on acfm_pkg.
`timescale 1ns / 1ps

module acfm_checker #(
  parameter int SYM_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  symbol,
  input  logic [31:0] new_frequency,
  input  logic [31:0] range_low,
  input  logic [31:0] range_high,
  input  logic [31:0] value_low,
  input  logic [31:0] value_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [31:0] interval_lo,
  input  logic [31:0] interval_hi,
  input  logic [31:0] symbol_frequency,
  input  logic [31:0] total_count,
  input  logic [7:0]  found_symbol,
  input  logic        found,
  output int          fail_count,
  output int          pending
);
  import acfm_pkg::*;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] lo;
    logic [31:0] up;
    logic [31:0] fr;
    logic [31:0] tot;
    logic [7:0]  fs;
    logic        fd;
  } bounds_t;

  localparam int LEAF_BASE = (1 << $clog2(SYM_COUNT)) - 1;

  logic [63:0] freq_m [SYM_COUNT];
  logic [63:0] total_m;
  bounds_t     expected_q [$];

  // prefix sums straight from the table; equivalent to the tree walk
  function automatic logic [63:0] cum_below(int unsigned code);
    logic [63:0] acc;
    acc = '0;
    for (int c = 0; c < SYM_COUNT && c < code; c++) acc += freq_m[c];
    return acc;
  endfunction

  function automatic logic [63:0] scaled(logic [63:0] cum);
    return (64'(ONE) * cum) / total_m;
  endfunction

  function automatic logic [63:0] point_at(logic [63:0] lo, logic [63:0] hi,
                                           logic [63:0] v);
    logic [63:0] span;
    span = (hi >= lo) ? hi - lo : 64'd0;
    return lo + (span * v) / 64'(ONE);
  endfunction

  function automatic bounds_t model_beat(logic [1:0] cmd, logic [7:0] sym,
      logic [31:0] nf, logic [31:0] rl, logic [31:0] rh, logic [31:0] vl,
      logic [31:0] vh);
    bounds_t r;
    logic [63:0] acc, c, cum;
    int unsigned node, leaf, lw, hi_leaf;
    r = '0;
    if (cmd == CMD_SET) begin
      if (sym >= SYM_COUNT) r.st = STAT_RANGE;
      else begin
        total_m = total_m - freq_m[sym] + 64'(nf);
        freq_m[sym] = 64'(nf);
        while (total_m > 64'(ONE))
          for (int k = 0; k < SYM_COUNT; k++)
            if (freq_m[k] > 64'd1) begin
              total_m -= freq_m[k] - freq_m[k] / 2;
              freq_m[k] = freq_m[k] / 2;
            end
        r.fr = freq_m[sym][31:0];
      end
    end else if (cmd == CMD_QUERY) begin
      if (sym >= SYM_COUNT) r.st = STAT_RANGE;
      else begin
        r.fr = freq_m[sym][31:0];
        if (total_m == 0) r.st = STAT_ZERO;
        else begin
          r.lo = 32'(scaled(cum_below(32'(sym))));
          r.up = 32'(scaled(cum_below(32'(sym) + 1)));
        end
      end
    end else if (cmd == CMD_FIND) begin
      if (total_m == 0) r.st = STAT_ZERO;
      else begin
        acc = '0;
        node = 0;
        while (node < LEAF_BASE) begin
          // left-subtree sum: leaves under the left child of this node
          hi_leaf = 2 * node + 1;
          while (hi_leaf < LEAF_BASE) hi_leaf = 2 * hi_leaf + 2;
          lw = 2 * node + 1;
          while (lw < LEAF_BASE) lw = 2 * lw + 1;
          c = acc + cum_below(hi_leaf - LEAF_BASE + 1) - cum_below(lw - LEAF_BASE);
          if (point_at(64'(rl), 64'(rh), scaled(c)) <= 64'(vl)) begin
            acc = c;
            node = 2 * node + 2;
          end else node = 2 * node + 1;
        end
        leaf = node - LEAF_BASE;
        cum = acc;
        if (leaf < SYM_COUNT) cum += freq_m[leaf];
        else r.st = STAT_RANGE;
        r.fs = leaf[7:0];
        r.fd = point_at(64'(rl), 64'(rh), scaled(cum)) >= 64'(vh);
      end
    end
    r.tot = total_m[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    bounds_t e, a;
    if (rst) begin
      for (int k = 0; k < SYM_COUNT; k++) freq_m[k] = 64'd1;
      total_m = 64'(SYM_COUNT);
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(model_beat(command, symbol, new_frequency, range_low,
                                        range_high, value_low, value_high));
      if (out_valid && out_ready) begin
        a = '{status, interval_lo, interval_hi, symbol_frequency, total_count,
              found_symbol, found};
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $time, a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

/* tb/tb_adaptive_cumfreq_interval_model.sv */
// Testbench top for adaptive_cumfreq_interval_model: directed and random commands
// under several idling phases, verdict from acfm_checker. Depends on acfm_pkg.
`timescale 1ns / 1ps

module tb_adaptive_cumfreq_interval_model;
  import acfm_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  command, status;
  logic [7:0]  symbol, found_symbol;
  logic [31:0] new_frequency, range_low, range_high, value_low, value_high;
  logic [31:0] interval_lo, interval_hi, symbol_frequency, total_count;
  logic found;
  int fail_count, pending, idle_cycles, send_idle, recv_stall;

  localparam int STALL_LIMIT = 400000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  adaptive_cumfreq_interval_model u_top (.*);
  acfm_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk)
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("adaptive_cumfreq_interval_model verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall);

  function automatic logic [31:0] rand_freq();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return $urandom_range(1 << 20);
      default: return $urandom_range(200);
    endcase
  endfunction

  // called at a falling edge; valid stays up into the next beat unless idling
  task automatic send_beat(logic [1:0] cmd, logic [7:0] sym, logic [31:0] nf,
      logic [31:0] rl, logic [31:0] rh, logic [31:0] vl, logic [31:0] vh);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; command <= cmd; symbol <= sym; new_frequency <= nf;
    range_low <= rl; range_high <= rh; value_low <= vl; value_high <= vh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_beat();
    logic [31:0] a, b, v, s, w, x, y, z, q;
    a = ($urandom_range(3) == 0) ? $urandom : 32'd0;
    b = ($urandom_range(3) == 0) ? $urandom : 32'h8000_0000;
    v = $urandom_range(32'h7fff_ffff);
    s = $urandom; w = $urandom; x = $urandom; y = $urandom; z = $urandom;
    q = $urandom;
    case ($urandom_range(9))
      0, 1: send_beat(CMD_SET, s[7:0], rand_freq(), w, x, y, z);
      2, 3, 4: send_beat(CMD_QUERY, s[7:0], q, w, x, y, z);
      5: send_beat(CMD_UNKNOWN, s[7:0], q, w, x, y, z);
      default: send_beat(CMD_FIND, s[7:0], q, a, b, v,
                         ($urandom_range(1) != 0) ? v + $urandom_range(1000) : w);
    endcase
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; out_ready = 1'b0; command = '0; symbol = '0;
    new_frequency = '0; range_low = '0; range_high = '0; value_low = '0;
    value_high = '0;
    send_idle = 0; recv_stall = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: extremes, rescale, reversed range, unknown command
    send_beat(CMD_QUERY, 8'd0, '0, '0, '0, '0, '0);
    send_beat(CMD_QUERY, 8'd255, '0, '0, '0, '0, '0);
    send_beat(CMD_FIND, 8'd0, '0, '0, 32'h8000_0000, '0, '0);
    send_beat(CMD_FIND, 8'd0, '0, '0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(CMD_FIND, 8'd0, '0, 32'hffff_ffff, '0, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_UNKNOWN, 8'hff, '1, '1, '1, '1, '1);
    send_beat(CMD_SET, 8'd7, 32'h8000_0000, '0, '0, '0, '0);
    send_beat(CMD_QUERY, 8'd7, '0, '0, '0, '0, '0);
    send_beat(CMD_SET, 8'd255, 32'hffff_ffff, '0, '0, '0, '0);
    send_beat(CMD_FIND, 8'd0, '0, '0, 32'h8000_0000, 32'h7fff_0000, 32'h7fff_ffff);
    send_beat(CMD_SET, 8'd0, '0, '0, '0, '0, '0);
    send_beat(CMD_QUERY, 8'd0, '0, '0, '0, '0, '0);
    send_beat(CMD_FIND, 8'd0, '0, '0, 32'h8000_0000, '0, 32'd1);
    for (int p = 0; p < 4; p++) begin
      send_idle  = (p == 1 || p == 3) ? ((p == 3) ? 6 : 79) : 0;
      recv_stall = (p == 2 || p == 3) ? ((p == 3) ? 6 : 79) : 0;
      repeat (250) random_beat();
    end
    // drive every symbol to zero so the zero-total status shows up
    for (int s = 0; s < 256; s++) send_beat(CMD_SET, 8'(s), '0, '0, '0, '0, '0);
    send_beat(CMD_QUERY, 8'd3, '0, '0, '0, '0, '0);
    send_beat(CMD_FIND, 8'd3, '0, '0, 32'h8000_0000, 32'd5, 32'd6);
    send_beat(CMD_QUERY, 8'd9, '0, '0, '0, '0, '0);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("adaptive_cumfreq_interval_model verification clean");
    else $display("adaptive_cumfreq_interval_model verification failed");
    $finish;
  end

endmodule
